// ----- src/seeq_pkg.sv -----
// Shared types and constants of the sensor event edge queue.
package seeq_pkg;

  localparam int unsigned TempW   = 11;
  localparam int unsigned BattW   = 7;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned QCountW = 4;
  localparam int unsigned DropW   = 3;
  localparam int unsigned NumSrc  = 6;   // event sources of one check, in check order

  // Request commands; code 3 is unused and changes nothing
  typedef enum logic [CmdW-1:0] {
    CMD_CHECK  = 2'd0,
    CMD_POP    = 2'd1,
    CMD_INJECT = 2'd2
  } seeq_cmd_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TEMP_WARN = 2'd0,
    REG_TEMP_CRIT = 2'd1,
    REG_BATT_LOW  = 2'd2,
    REG_BATT_CRIT = 2'd3
  } seeq_reg_e;

  // Event codes
  localparam logic [CodeW-1:0] EV_TEMP_WARN  = 8'd1;
  localparam logic [CodeW-1:0] EV_TEMP_CRIT  = 8'd2;
  localparam logic [CodeW-1:0] EV_BATT_LOW   = 8'd3;
  localparam logic [CodeW-1:0] EV_BATT_CRIT  = 8'd4;
  localparam logic [CodeW-1:0] EV_LID_CLOSED = 8'd5;
  localparam logic [CodeW-1:0] EV_LID_OPENED = 8'd6;
  localparam logic [CodeW-1:0] EV_AC_ON      = 8'd7;
  localparam logic [CodeW-1:0] EV_AC_OFF     = 8'd8;

  localparam logic [BattW-1:0] BattMax = 7'd100;

  // Threshold reset values
  localparam logic [TempW-1:0] TempWarnRst = 11'd600;
  localparam logic [TempW-1:0] TempCritRst = 11'd750;
  localparam logic [BattW-1:0] BattLowRst  = 7'd20;
  localparam logic [BattW-1:0] BattCritRst = 7'd5;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [TempW-1:0] temperature;
    logic [BattW-1:0] battery_percent;
    logic             lid_is_open;
    logic             ac_present;
    logic [CodeW-1:0] inject_code;
  } seeq_req_t;

  typedef struct packed {
    logic               alert_pending;
    logic [CodeW-1:0]   latest_event;
    logic [CodeW-1:0]   popped_event;
    logic [QCountW-1:0] queued_count;
    logic [7:0]         raised_mask;
    logic [DropW-1:0]   dropped_count;
  } seeq_rsp_t;

endpackage

// ----- src/seeq_if.sv -----
// Request and response channel interfaces of the sensor event edge queue.
interface seeq_req_if;
  import seeq_pkg::*;
  logic      valid;
  logic      ready;
  seeq_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface seeq_rsp_if;
  import seeq_pkg::*;
  logic      valid;
  logic      ready;
  seeq_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/sensor_event_edge_queue.sv -----
// Sensor event edge queue: threshold edge detection feeding a circular event FIFO.
// A request is taken into the input register, then worked into the response register
// when the response register is empty or its response is being taken.
// Throughput: one request per cycle without response stalls, set by the single pass.
// Reset (rst_ni low, asynchronous): pointers, flags, edge history and thresholds take
// their reset values; the event store itself is not cleared.
module sensor_event_edge_queue #(
  parameter int unsigned QUEUE_SLOTS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  seeq_req_if.sink              evt_req_i,
  seeq_rsp_if.source            evt_rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import seeq_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_SLOTS);
  localparam int unsigned CntW = $clog2(QUEUE_SLOTS + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QUEUE_SLOTS - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(QUEUE_SLOTS - 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == LastSlot) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [CntW-1:0] used_of(input logic [PtrW-1:0] w,
                                              input logic [PtrW-1:0] r);
    if (w >= r) begin
      used_of = CntW'(w) - CntW'(r);
    end else begin
      used_of = CntW'(w) + CntW'(QUEUE_SLOTS) - CntW'(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [TempW-1:0] temp_warn_q, temp_crit_q;
  logic [BattW-1:0] batt_low_q, batt_crit_q;
  logic             cfg_wr;
  seeq_reg_e        cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = seeq_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_warn_q <= TempWarnRst;
      temp_crit_q <= TempCritRst;
      batt_low_q  <= BattLowRst;
      batt_crit_q <= BattCritRst;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_TEMP_WARN: temp_warn_q <= pwdata[TempW-1:0];
        REG_TEMP_CRIT: temp_crit_q <= pwdata[TempW-1:0];
        REG_BATT_LOW:  batt_low_q  <= pwdata[BattW-1:0];
        REG_BATT_CRIT: batt_crit_q <= pwdata[BattW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_TEMP_WARN: prdata = 32'(temp_warn_q);
      REG_TEMP_CRIT: prdata = 32'(temp_crit_q);
      REG_BATT_LOW:  prdata = 32'(batt_low_q);
      REG_BATT_CRIT: prdata = 32'(batt_crit_q);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register and response register
  logic      in_valid_q, out_valid_q;
  seeq_req_t in_q;
  seeq_rsp_t rsp_q;
  logic [CodeW-1:0] popped_q;
  logic      adv, work;

  assign adv             = !out_valid_q || evt_rsp_o.ready;
  assign work            = in_valid_q && adv;
  assign evt_req_i.ready = !in_valid_q || adv;
  assign evt_rsp_o.valid = out_valid_q;

  always_comb begin
    evt_rsp_o.data              = rsp_q;
    evt_rsp_o.data.popped_event = popped_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (evt_req_i.ready) begin
        in_valid_q <= evt_req_i.valid;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_req_i.valid && evt_req_i.ready) begin
      in_q <= evt_req_i.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Queue and edge state
  logic [PtrW-1:0]  wp_q, rp_q, wp_d, rp_d;
  logic             pending_q, pending_d;
  logic [CodeW-1:0] last_q, last_d;
  logic             prev_warm_q, prev_hot_q, prev_low_q, prev_empty_q;
  logic             prev_lid_q, prev_ac_q;
  logic             prev_warm_d, prev_hot_d, prev_low_d, prev_empty_d;
  logic             prev_lid_d, prev_ac_d;
  logic [CodeW-1:0] store_q [QUEUE_SLOTS];

  // Per-source push lanes
  logic [NumSrc-1:0] raise;
  logic [CodeW-1:0]  code   [NumSrc];
  logic [NumSrc-1:0] we;
  logic [PtrW-1:0]   waddr  [NumSrc];
  logic [PtrW-1:0]   ptr;
  logic [CntW-1:0]   free_cnt, used_cur, used_new;
  logic [CntW+QCountW-1:0] used_ext;
  logic [DropW-1:0]  drop;
  logic [7:0]        mask;
  logic [BattW-1:0]  batt;
  logic              warm, hot, low, empty, pop_hit;
  seeq_rsp_t         rsp_d;

  // One request worked against the current state
  always_comb begin
    wp_d         = wp_q;
    rp_d         = rp_q;
    pending_d    = pending_q;
    last_d       = last_q;
    prev_warm_d  = prev_warm_q;
    prev_hot_d   = prev_hot_q;
    prev_low_d   = prev_low_q;
    prev_empty_d = prev_empty_q;
    prev_lid_d   = prev_lid_q;
    prev_ac_d    = prev_ac_q;
    raise        = '0;
    mask         = '0;
    pop_hit      = 1'b0;
    for (int k = 0; k < NumSrc; k++) begin
      code[k]  = '0;
      we[k]    = 1'b0;
      waddr[k] = '0;
    end

    batt  = (in_q.battery_percent > BattMax) ? BattMax : in_q.battery_percent;
    warm  = in_q.temperature >= temp_warn_q;
    hot   = in_q.temperature >= temp_crit_q;
    low   = batt <= batt_low_q;
    empty = batt <= batt_crit_q;

    used_cur = used_of(wp_q, rp_q);
    free_cnt = FullCnt - used_cur;

    unique case (seeq_cmd_e'(in_q.command))
      CMD_CHECK: begin
        raise[0] = warm && !prev_warm_q;
        code[0]  = EV_TEMP_WARN;
        raise[1] = hot && !prev_hot_q;
        code[1]  = EV_TEMP_CRIT;
        raise[2] = low && !prev_low_q;
        code[2]  = EV_BATT_LOW;
        raise[3] = empty && !prev_empty_q;
        code[3]  = EV_BATT_CRIT;
        raise[4] = in_q.lid_is_open != prev_lid_q;
        code[4]  = in_q.lid_is_open ? EV_LID_OPENED : EV_LID_CLOSED;
        raise[5] = in_q.ac_present != prev_ac_q;
        code[5]  = in_q.ac_present ? EV_AC_ON : EV_AC_OFF;
        mask = {raise[5] && !in_q.ac_present, raise[5] && in_q.ac_present,
                raise[4] && in_q.lid_is_open, raise[4] && !in_q.lid_is_open,
                raise[3:0]};
        prev_warm_d  = warm;
        prev_hot_d   = hot;
        prev_low_d   = low;
        prev_empty_d = empty;
        prev_lid_d   = in_q.lid_is_open;
        prev_ac_d    = in_q.ac_present;
      end
      CMD_POP: begin
        if (rp_q != wp_q) begin
          pop_hit = 1'b1;
          rp_d    = ptr_inc(rp_q);
          if (rp_d == wp_q) begin
            pending_d = 1'b0;
            last_d    = '0;
          end
        end
      end
      CMD_INJECT: begin
        raise[0] = 1'b1;
        code[0]  = in_q.inject_code;
      end
      default: begin
      end
    endcase

    // Enqueue raised events in order; the ones past the free room are dropped
    ptr  = wp_q;
    drop = '0;
    for (int k = 0; k < NumSrc; k++) begin
      if (raise[k]) begin
        if (free_cnt != '0) begin
          we[k]     = 1'b1;
          waddr[k]  = ptr;
          ptr       = ptr_inc(ptr);
          free_cnt  = free_cnt - 1'b1;
          pending_d = 1'b1;
          last_d    = code[k];
        end else begin
          drop = drop + 1'b1;
        end
      end
    end
    if (seeq_cmd_e'(in_q.command) != CMD_POP) begin
      wp_d = ptr;
    end

    used_new = used_of(wp_d, rp_d);
    used_ext = {{QCountW{1'b0}}, used_new};

    rsp_d.alert_pending = pending_d;
    rsp_d.latest_event  = last_d;
    rsp_d.popped_event  = '0;
    rsp_d.queued_count  = used_ext[QCountW-1:0];
    rsp_d.raised_mask   = mask;
    rsp_d.dropped_count = drop;
  end

  // State update on each worked request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      rp_q         <= '0;
      pending_q    <= 1'b0;
      last_q       <= '0;
      prev_warm_q  <= 1'b0;
      prev_hot_q   <= 1'b0;
      prev_low_q   <= 1'b0;
      prev_empty_q <= 1'b0;
      prev_lid_q   <= 1'b1;
      prev_ac_q    <= 1'b1;
    end else if (work) begin
      wp_q         <= wp_d;
      rp_q         <= rp_d;
      pending_q    <= pending_d;
      last_q       <= last_d;
      prev_warm_q  <= prev_warm_d;
      prev_hot_q   <= prev_hot_d;
      prev_low_q   <= prev_low_d;
      prev_empty_q <= prev_empty_d;
      prev_lid_q   <= prev_lid_d;
      prev_ac_q    <= prev_ac_d;
    end
  end

  // Response register and event store (write lanes hit distinct slots)
  always_ff @(posedge clk_i) begin
    if (work) begin
      rsp_q    <= rsp_d;
      popped_q <= pop_hit ? store_q[rp_q] : '0;
      for (int k = 0; k < NumSrc; k++) begin
        if (we[k]) begin
          store_q[waddr[k]] <= code[k];
        end
      end
    end
  end

`ifndef SYNTH
  // Occupancy never exceeds one less than the slot count
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_of(wp_q, rp_q) <= FullCnt)
    else $error("event queue occupancy out of range");

  // An empty queue carries no pending flag and no latest code
  a_empty_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q == rp_q) |-> (!pending_q && (last_q == '0)))
    else $error("pending state left over on empty queue");

  // A response that reports drops belongs to a full queue
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (rsp_q.dropped_count != '0)) |-> (used_of(wp_q, rp_q) == FullCnt))
    else $error("drop reported while queue had room");
`endif

endmodule
